// ===== rtl/core/sst_pkg.sv =====
package sst_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int MODE_W      = 2;
    localparam int SITE_W      = 16;
    localparam int RANK_W      = 7;
    localparam int COUNT_OUT_W = 7;
    localparam int STATUS_W    = 2;
    localparam int CMP_W       = (CNT_W > RANK_W) ? CNT_W : RANK_W;

    // Input tdata layout, lowest bit first.
    localparam int IN_MODE_LSB   = 0;
    localparam int IN_SITE_LSB   = IN_MODE_LSB + MODE_W;
    localparam int IN_EFFECT_LSB = IN_SITE_LSB + SITE_W;
    localparam int IN_RANK_LSB   = IN_EFFECT_LSB + 1;
    localparam int IN_BITS       = IN_RANK_LSB + RANK_W;
    localparam int IN_TDATA_W    = ((IN_BITS + 7) / 8) * 8;

    // Output tdata layout, lowest bit first.
    localparam int OUT_EMPTY_LSB  = 0;
    localparam int OUT_ENTRY_LSB  = OUT_EMPTY_LSB + 1;
    localparam int OUT_EFFECT_LSB = OUT_ENTRY_LSB + COUNT_OUT_W;
    localparam int OUT_STATUS_LSB = OUT_EFFECT_LSB + COUNT_OUT_W;
    localparam int OUT_BITS       = OUT_STATUS_LSB + STATUS_W;
    localparam int OUT_TDATA_W    = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT = 2'd0,
        MODE_DELETE = 2'd1,
        MODE_TEST   = 2'd2
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK       = 2'd0,
        STAT_RANK_ERR = 2'd1,
        STAT_FULL     = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_STEP,
        ST_INS_HEAD,
        ST_DEL_FIRST,
        ST_DEL_MOVE,
        ST_TST_STEP,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic              effect;
        logic [SITE_W-1:0] site;
    } entry_t;

    function automatic logic [COUNT_OUT_W-1:0] to_out_count(input logic [CNT_W-1:0] c);
        logic [CNT_W+COUNT_OUT_W-1:0] w;
        begin
            w = {{COUNT_OUT_W{1'b0}}, c};
            return w[COUNT_OUT_W-1:0];
        end
    endfunction

endpackage

// ===== rtl/core/sorted_site_table.sv =====
// Sorted location table of up to 64 entries held in a single-port-write,
// single-port-read memory. Each transaction takes one operation and returns
// exactly one result. All work runs through one read/compare/write step per
// cycle: an insert walks down from the last entry, moving each larger entry
// up one place; a delete walks up from the removed rank, moving each later
// entry down; a location test scans from the first entry and stops at the
// first location not below the probe. Errors, a full table, a test of an
// empty table and the unused mode code go straight to the finish state.
// s_tready is high only while no operation is in work; a finished result
// waits in the output register, and the next transaction is still taken,
// but it holds in its finish state until that result is taken.
module sorted_site_table
    import sst_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // mode[1:0], site[17:2], has_effect[18], rank[25:19], zero fill above
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // site_empty[0], entry_count[7:1], effect_count[14:8], status[16:15], zero fill above
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    entry_t mem [TABLE_DEPTH];
    entry_t rd_data_reg;

    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;

    state_t state_reg, state_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [CNT_W-1:0] eff_cnt_reg, eff_cnt_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    entry_t           new_reg, new_next;
    status_t          status_reg, status_next;
    logic             empty_reg, empty_next;
    logic             out_valid_reg, out_valid_next;
    logic [OUT_TDATA_W-1:0] out_data_reg, out_data_next;

    logic [MODE_W-1:0] in_mode;
    logic [SITE_W-1:0] in_site;
    logic              in_effect;
    logic [RANK_W-1:0] in_rank;
    logic              accept;
    logic              more_after;

    assign in_mode   = s_tdata[IN_MODE_LSB +: MODE_W];
    assign in_site   = s_tdata[IN_SITE_LSB +: SITE_W];
    assign in_effect = s_tdata[IN_EFFECT_LSB];
    assign in_rank   = s_tdata[IN_RANK_LSB +: RANK_W];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // True when an entry follows the one at idx_reg.
    assign more_after = ((CNT_W'(idx_reg) + CNT_W'(1)) < fill_reg);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            eff_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            eff_cnt_reg   <= eff_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        new_reg      <= new_next;
        status_reg   <= status_next;
        empty_reg    <= empty_next;
        out_data_reg <= out_data_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        eff_cnt_next   = eff_cnt_reg;
        idx_next       = idx_reg;
        new_next       = new_reg;
        status_next    = status_reg;
        empty_next     = empty_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        rd_en          = 1'b0;
        rd_addr        = '0;
        wr_en          = 1'b0;
        wr_addr        = '0;
        wr_data        = rd_data_reg;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    new_next.site   = in_site;
                    new_next.effect = in_effect;
                    status_next     = STAT_OK;
                    empty_next      = 1'b0;
                    state_next      = ST_FINISH;
                    unique case (in_mode)
                        MODE_INSERT:
                        begin
                            if (fill_reg == CNT_W'(TABLE_DEPTH))
                            begin
                                status_next = STAT_FULL;
                            end
                            else if (fill_reg == '0)
                            begin
                                state_next = ST_INS_HEAD;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = IDX_W'(fill_reg - CNT_W'(1));
                                idx_next   = IDX_W'(fill_reg);
                                state_next = ST_INS_STEP;
                            end
                        end
                        MODE_DELETE:
                        begin
                            if (in_rank == '0 || CMP_W'(in_rank) > CMP_W'(fill_reg))
                            begin
                                status_next = STAT_RANK_ERR;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = IDX_W'(in_rank - RANK_W'(1));
                                idx_next   = IDX_W'(in_rank - RANK_W'(1));
                                state_next = ST_DEL_FIRST;
                            end
                        end
                        MODE_TEST:
                        begin
                            if (fill_reg == '0)
                            begin
                                empty_next = 1'b1;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = '0;
                                idx_next   = '0;
                                state_next = ST_TST_STEP;
                            end
                        end
                        default:
                        begin
                            // The unused mode code leaves the table alone.
                        end
                    endcase
                end
            end

            ST_INS_STEP:
            begin
                // rd_data_reg holds the entry just below the write slot idx_reg.
                wr_en   = 1'b1;
                wr_addr = idx_reg;
                if (rd_data_reg.site > new_reg.site)
                begin
                    wr_data = rd_data_reg;
                    if (idx_reg == IDX_W'(1))
                    begin
                        state_next = ST_INS_HEAD;
                    end
                    else
                    begin
                        rd_en    = 1'b1;
                        rd_addr  = idx_reg - IDX_W'(2);
                        idx_next = idx_reg - IDX_W'(1);
                    end
                end
                else
                begin
                    wr_data      = new_reg;
                    fill_next    = fill_reg + CNT_W'(1);
                    eff_cnt_next = eff_cnt_reg + CNT_W'(new_reg.effect);
                    state_next   = ST_FINISH;
                end
            end

            ST_INS_HEAD:
            begin
                wr_en        = 1'b1;
                wr_addr      = '0;
                wr_data      = new_reg;
                fill_next    = fill_reg + CNT_W'(1);
                eff_cnt_next = eff_cnt_reg + CNT_W'(new_reg.effect);
                state_next   = ST_FINISH;
            end

            ST_DEL_FIRST, ST_DEL_MOVE:
            begin
                if (state_reg == ST_DEL_FIRST)
                begin
                    // This is the entry being removed.
                    eff_cnt_next = eff_cnt_reg - CNT_W'(rd_data_reg.effect);
                end
                else
                begin
                    wr_en   = 1'b1;
                    wr_addr = idx_reg - IDX_W'(1);
                    wr_data = rd_data_reg;
                end
                if (more_after)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = idx_reg + IDX_W'(1);
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = ST_DEL_MOVE;
                end
                else
                begin
                    fill_next  = fill_reg - CNT_W'(1);
                    state_next = ST_FINISH;
                end
            end

            ST_TST_STEP:
            begin
                if (rd_data_reg.site == new_reg.site)
                begin
                    empty_next = 1'b0;
                    state_next = ST_FINISH;
                end
                else if (rd_data_reg.site > new_reg.site || !more_after)
                begin
                    empty_next = 1'b1;
                    state_next = ST_FINISH;
                end
                else
                begin
                    rd_en    = 1'b1;
                    rd_addr  = idx_reg + IDX_W'(1);
                    idx_next = idx_reg + IDX_W'(1);
                end
            end

            ST_FINISH:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = '0;
                    out_data_next[OUT_EMPTY_LSB]                  = empty_reg;
                    out_data_next[OUT_ENTRY_LSB +: COUNT_OUT_W]   = to_out_count(fill_reg);
                    out_data_next[OUT_EFFECT_LSB +: COUNT_OUT_W]  = to_out_count(eff_cnt_reg);
                    out_data_next[OUT_STATUS_LSB +: STATUS_W]     = status_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count exceeds table depth");

    a_effect_bound: assert property (@(posedge clk) disable iff (!rst_n)
        eff_cnt_reg <= fill_reg)
        else $error("effect count exceeds entry count");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("ready stayed high after a transaction was taken");

endmodule
